FILE: hw/rtl/btc_pkg.sv
package btc_pkg;

  localparam int MAX_WINDOW_DEF = 16;

  localparam int PITCH_W  = 14;
  localparam int RATE_W   = 20;
  localparam int GAIN_W   = 16;
  localparam int WLEN_W   = 5;
  localparam int CMD_W    = 24;
  localparam int TORQUE_W = 17;
  localparam int INTEG_W  = 32;

  localparam logic [GAIN_W-1:0] PITCH_GAIN_RST    = 16'd20480;
  localparam logic [GAIN_W-1:0] RATE_GAIN_RST     = 16'd40960;
  localparam logic [GAIN_W-1:0] BOUND_SLOPE_RST   = 16'd2867;
  localparam logic [GAIN_W-1:0] INTEGRAL_GAIN_RST = 16'd328;
  localparam logic [GAIN_W-1:0] COMMAND_LIMIT_RST = 16'd4096;
  localparam logic [GAIN_W-1:0] OUTPUT_SCALE_RST  = 16'd7282;
  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST    = 5'd10;

  localparam logic signed [CMD_W-1:0] CMD_MAX = 24'sh7FFFFF;
  localparam logic signed [CMD_W-1:0] CMD_MIN = -24'sh800000;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 32'sh7FFFFFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = -32'sh80000000;

  typedef enum logic [2:0] {
    CFG_PITCH_GAIN    = 3'd0,
    CFG_RATE_GAIN     = 3'd1,
    CFG_BOUND_SLOPE   = 3'd2,
    CFG_INTEGRAL_GAIN = 3'd3,
    CFG_COMMAND_LIMIT = 3'd4,
    CFG_OUTPUT_SCALE  = 3'd5,
    CFG_WINDOW_LEN    = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_BOUND,
    ST_LIMIT,
    ST_CLAMP,
    ST_ROUND,
    ST_SCALE,
    ST_WRITE,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

FILE: hw/rtl/btc_div.sv
module btc_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;

  logic [DEN_W:0]   trial;
  logic             qbit;
  logic [DEN_W-1:0] rem_nxt;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: hw/rtl/balance_torque_controller_core.sv
// channel  | direction | payload                                        | flow
// in_      | input     | pitch_angle s14, pitch_rate s20                | valid / stall
// out_     | output    | wheel_command s24, optimal_torque s17, infeasible | valid / stall
// cfg_     | input     | index 3 bits, data 16 bits                     | write enable
//
// the history sum reads the n entries, n being the fill count after the item
// (1 .. MAX_WINDOW), one memory entry per cycle, and the mean comes from a radix-2
// divider that runs 24 + log2(MAX_WINDOW) steps
// the input stalls until the result sits in the output register; one result may wait
// there while the next item is taken
// reset (rst_n low, synchronous) restores the configuration registers and clears the integral,
// write position and fill count; the history memory is not cleared
module balance_torque_controller_core #(
  parameter int MAX_WINDOW = btc_pkg::MAX_WINDOW_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [btc_pkg::PITCH_W-1:0]    in_pitch_angle,
  input  logic signed [btc_pkg::RATE_W-1:0]     in_pitch_rate,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [btc_pkg::CMD_W-1:0]      out_wheel_command,
  output logic signed [btc_pkg::TORQUE_W-1:0]   out_optimal_torque,
  output logic                                  out_infeasible,
  input  logic                                  cfg_we,
  input  logic [2:0]                            cfg_addr,
  input  logic [btc_pkg::GAIN_W-1:0]            cfg_wdata
);

  localparam int LOG_W = $clog2(MAX_WINDOW);
  localparam int AW    = (MAX_WINDOW > 1) ? LOG_W : 1;
  localparam int NW    = $clog2(MAX_WINDOW + 1);
  localparam int SUMW  = btc_pkg::CMD_W + LOG_W;

  localparam int P1W = 30;
  localparam int P2W = 36;
  localparam int SW  = 30;
  localparam int PCW = 48;
  localparam int TW  = 37;
  localparam int BW  = 45;
  localparam int XW  = 29;
  localparam int CPW = 33;

  // configuration
  logic [btc_pkg::GAIN_W-1:0] pitch_gain_r, rate_gain_r, bound_slope_r;
  logic [btc_pkg::GAIN_W-1:0] integral_gain_r, command_limit_r, output_scale_r;
  logic [btc_pkg::WLEN_W-1:0] window_len_r;

  // control
  btc_pkg::state_t state_r, state_nxt;
  logic                               out_valid_r;
  logic signed [btc_pkg::INTEG_W-1:0] integ_r;
  logic [AW-1:0]                      wp_r;
  logic [NW-1:0]                      fill_r;
  logic [NW-1:0]                      rd_cnt_r;
  logic                               acc_vld_r;

  // datapath
  logic signed [btc_pkg::PITCH_W-1:0]  pitch_r;
  logic signed [btc_pkg::RATE_W-1:0]   rate_r;
  logic signed [P1W-1:0]               p1_r;
  logic signed [P2W-1:0]               p2_r;
  logic [SW-1:0]                       s_r;
  logic signed [PCW-1:0]               pc_r;
  logic signed [TW-1:0]                t_r;
  logic signed [BW-1:0]                lo_r, hi_r, lower_r, upper_r;
  logic signed [XW-1:0]                tl_r, x_r;
  logic                                infeas_r;
  logic signed [btc_pkg::TORQUE_W-1:0] torque_r;
  logic signed [CPW-1:0]               cprod_r;
  logic signed [SUMW-1:0]              sum_r;
  logic signed [btc_pkg::CMD_W-1:0]    rd_data_r;
  logic signed [btc_pkg::CMD_W-1:0]    out_cmd_r;
  logic signed [btc_pkg::TORQUE_W-1:0] out_torque_r;
  logic                                out_infeas_r;

  logic signed [btc_pkg::CMD_W-1:0] hist_mem [MAX_WINDOW];

  // sequencer controls
  logic in_xfer, out_xfer, mem_we, rd_en, div_start, out_load;
  logic div_done;
  logic [SUMW-1:0] div_quo;

  // combinational values
  logic [NW-1:0]                      wl_eff;
  logic signed [btc_pkg::INTEG_W:0]   integ_sum;
  logic signed [btc_pkg::INTEG_W-1:0] integ_sat;
  logic [btc_pkg::PITCH_W-1:0]        pitch_abs;
  logic signed [BW-1:0]               c_val;
  logic signed [XW-1:0]               lim;
  logic signed [BW-1:0]               lim_w, t_w;
  logic signed [TW-1:0]               lim_t;
  logic signed [BW-1:0]               x_clip;
  logic signed [XW:0]                 x_rnd;
  logic signed [CPW:0]                cmd_rnd;
  logic signed [CPW:0]                cmd_full;
  logic signed [btc_pkg::CMD_W-1:0]   cmd_sat;
  logic [SUMW-1:0]                    sum_u;
  logic [SUMW-1:0]                    half_n;
  logic [SUMW-1:0]                    mag;
  logic signed [SUMW:0]               avg_s;
  logic signed [btc_pkg::CMD_W-1:0]   avg_sat;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  always_comb begin
    if (window_len_r == '0) begin
      wl_eff = NW'(1);
    end else if (32'(window_len_r) > 32'(MAX_WINDOW)) begin
      wl_eff = NW'(MAX_WINDOW);
    end else begin
      wl_eff = NW'(window_len_r);
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      btc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = btc_pkg::ST_PROD;
        end
      end
      btc_pkg::ST_PROD:  state_nxt = btc_pkg::ST_BOUND;
      btc_pkg::ST_BOUND: state_nxt = btc_pkg::ST_LIMIT;
      btc_pkg::ST_LIMIT: state_nxt = btc_pkg::ST_CLAMP;
      btc_pkg::ST_CLAMP: state_nxt = btc_pkg::ST_ROUND;
      btc_pkg::ST_ROUND: state_nxt = btc_pkg::ST_SCALE;
      btc_pkg::ST_SCALE: state_nxt = btc_pkg::ST_WRITE;
      btc_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        state_nxt = btc_pkg::ST_SUM;
      end
      btc_pkg::ST_SUM: begin
        rd_en = (rd_cnt_r < fill_r);
        if (!rd_en && !acc_vld_r) begin
          state_nxt = btc_pkg::ST_PREP;
        end
      end
      btc_pkg::ST_PREP: begin
        div_start = 1'b1;
        state_nxt = btc_pkg::ST_DIV;
      end
      btc_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = btc_pkg::ST_DONE;
        end
      end
      btc_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = btc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btc_pkg::ST_IDLE;
    endcase
  end

  // arithmetic
  always_comb begin
    integ_sum = (btc_pkg::INTEG_W + 1)'(integ_r) + (btc_pkg::INTEG_W + 1)'(in_pitch_angle);
    if (integ_sum[btc_pkg::INTEG_W] != integ_sum[btc_pkg::INTEG_W-1]) begin
      integ_sat = integ_sum[btc_pkg::INTEG_W] ? btc_pkg::INTEG_MIN : btc_pkg::INTEG_MAX;
    end else begin
      integ_sat = integ_sum[btc_pkg::INTEG_W-1:0];
    end

    pitch_abs = pitch_r[btc_pkg::PITCH_W-1] ? (~pitch_r + 1'b1) : pitch_r;

    c_val = BW'(pc_r >>> 4);

    lim   = {1'b0, command_limit_r, 12'h000};
    lim_w = BW'(lim);
    lim_t = TW'(lim);
    t_w   = BW'(t_r);

    if (t_w < lower_r) begin
      x_clip = lower_r;
    end else if (t_w > upper_r) begin
      x_clip = upper_r;
    end else begin
      x_clip = t_w;
    end

    x_rnd = (XW + 1)'(x_r) + (XW + 1)'(2048);

    cmd_rnd  = (CPW + 1)'(cprod_r) + (CPW + 1)'(2048);
    cmd_full = cmd_rnd >>> 12;
    if (cmd_full > (CPW + 1)'(btc_pkg::CMD_MAX)) begin
      cmd_sat = btc_pkg::CMD_MAX;
    end else if (cmd_full < (CPW + 1)'(btc_pkg::CMD_MIN)) begin
      cmd_sat = btc_pkg::CMD_MIN;
    end else begin
      cmd_sat = btc_pkg::CMD_W'(cmd_full);
    end

    // |sum| + n/2 in one add or subtract
    sum_u  = sum_r;
    half_n = SUMW'(fill_r >> 1);
    mag    = sum_r[SUMW-1] ? (half_n - sum_u) : (sum_u + half_n);

    avg_s = sum_r[SUMW-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    if (avg_s > (SUMW + 1)'(btc_pkg::CMD_MAX)) begin
      avg_sat = btc_pkg::CMD_MAX;
    end else if (avg_s < (SUMW + 1)'(btc_pkg::CMD_MIN)) begin
      avg_sat = btc_pkg::CMD_MIN;
    end else begin
      avg_sat = btc_pkg::CMD_W'(avg_s);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_gain_r    <= btc_pkg::PITCH_GAIN_RST;
      rate_gain_r     <= btc_pkg::RATE_GAIN_RST;
      bound_slope_r   <= btc_pkg::BOUND_SLOPE_RST;
      integral_gain_r <= btc_pkg::INTEGRAL_GAIN_RST;
      command_limit_r <= btc_pkg::COMMAND_LIMIT_RST;
      output_scale_r  <= btc_pkg::OUTPUT_SCALE_RST;
      window_len_r    <= btc_pkg::WINDOW_LEN_RST;
      out_valid_r     <= 1'b0;
      integ_r         <= '0;
      wp_r            <= '0;
      fill_r          <= '0;
      rd_cnt_r        <= '0;
      acc_vld_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          btc_pkg::CFG_PITCH_GAIN:    pitch_gain_r    <= cfg_wdata;
          btc_pkg::CFG_RATE_GAIN:     rate_gain_r     <= cfg_wdata;
          btc_pkg::CFG_BOUND_SLOPE:   bound_slope_r   <= cfg_wdata;
          btc_pkg::CFG_INTEGRAL_GAIN: integral_gain_r <= cfg_wdata;
          btc_pkg::CFG_COMMAND_LIMIT: command_limit_r <= cfg_wdata;
          btc_pkg::CFG_OUTPUT_SCALE:  output_scale_r  <= cfg_wdata;
          btc_pkg::CFG_WINDOW_LEN:    window_len_r    <= cfg_wdata[btc_pkg::WLEN_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        integ_r <= integ_sat;
      end
      if (mem_we) begin
        wp_r     <= (NW'(wp_r) + NW'(1) >= wl_eff) ? '0 : wp_r + AW'(1);
        fill_r   <= (fill_r >= wl_eff) ? wl_eff : fill_r + NW'(1);
        rd_cnt_r <= '0;
      end else if (rd_en) begin
        rd_cnt_r <= rd_cnt_r + NW'(1);
      end
      acc_vld_r <= rd_en;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pitch_r <= in_pitch_angle;
      rate_r  <= in_pitch_rate;
    end
    case (state_r)
      btc_pkg::ST_PROD: begin
        p1_r <= P1W'($signed({1'b0, pitch_gain_r})) * P1W'(pitch_r);
        p2_r <= P2W'($signed({1'b0, rate_gain_r})) * P2W'(rate_r);
        s_r  <= SW'(bound_slope_r) * SW'(pitch_abs);
        pc_r <= PCW'($signed({1'b0, integral_gain_r})) * PCW'(integ_r);
      end
      btc_pkg::ST_BOUND: begin
        t_r  <= TW'(p1_r) + TW'(p2_r);
        lo_r <= c_val - BW'($signed({1'b0, s_r}));
        hi_r <= c_val + BW'($signed({1'b0, s_r}));
      end
      btc_pkg::ST_LIMIT: begin
        lower_r <= (lo_r > -lim_w) ? lo_r : -lim_w;
        upper_r <= (hi_r < lim_w) ? hi_r : lim_w;
        if (t_r < -lim_t) begin
          tl_r <= -lim;
        end else if (t_r > lim_t) begin
          tl_r <= lim;
        end else begin
          tl_r <= XW'(t_r);
        end
      end
      btc_pkg::ST_CLAMP: begin
        infeas_r <= (lower_r > upper_r);
        x_r      <= (lower_r > upper_r) ? tl_r : XW'(x_clip);
      end
      btc_pkg::ST_ROUND: begin
        torque_r <= btc_pkg::TORQUE_W'(x_rnd >>> 12);
      end
      btc_pkg::ST_SCALE: begin
        cprod_r <= CPW'(torque_r) * CPW'($signed({1'b0, output_scale_r}));
      end
      btc_pkg::ST_WRITE: begin
        sum_r <= '0;
      end
      btc_pkg::ST_SUM: begin
        if (acc_vld_r) begin
          sum_r <= sum_r + SUMW'(rd_data_r);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_cmd_r    <= avg_sat;
      out_torque_r <= torque_r;
      out_infeas_r <= infeas_r;
    end
  end

  // command history
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wp_r] <= cmd_sat;
    end
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_cnt_r[AW-1:0]];
    end
  end

  btc_div #(
    .NUM_W (SUMW),
    .DEN_W (NW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mag),
    .den   (fill_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid          = out_valid_r;
  assign out_wheel_command  = out_cmd_r;
  assign out_optimal_torque = out_torque_r;
  assign out_infeasible     = out_infeas_r;

`ifndef NO_ASSERTIONS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == btc_pkg::ST_DONE))
    else $error("result appeared outside the done state");

  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == btc_pkg::ST_DIV)
    else $error("divider finished while sequencer was not waiting");

  a_sum_complete: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == btc_pkg::ST_PREP |-> (fill_r != '0 && rd_cnt_r == fill_r))
    else $error("window sum did not cover the fill count");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == btc_pkg::ST_PROD)
    else $error("transfer did not start the product stage");
`endif

endmodule

FILE: tb/balance_torque_controller_core_chk.sv
`timescale 1ns / 100ps
module balance_torque_controller_core_chk (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [btc_pkg::PITCH_W-1:0]    in_pitch_angle,
  input  logic signed [btc_pkg::RATE_W-1:0]     in_pitch_rate,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [btc_pkg::CMD_W-1:0]      out_wheel_command,
  input  logic signed [btc_pkg::TORQUE_W-1:0]   out_optimal_torque,
  input  logic                                  out_infeasible,
  input  logic                                  cfg_we,
  input  logic [2:0]                            cfg_addr,
  input  logic [btc_pkg::GAIN_W-1:0]            cfg_wdata,
  output int                                    outstanding,
  output int                                    fail_count
);
  import btc_pkg::*;

  typedef struct packed {
    logic signed [CMD_W-1:0]    wheel;
    logic signed [TORQUE_W-1:0] torque;
    logic                       infeasible;
  } tick_result_t;

  tick_result_t ticks_due[$];

  logic [GAIN_W-1:0] k_pitch, k_rate, slope, k_integ, limit, scale;
  logic [WLEN_W-1:0] win_len;

  logic signed [INTEG_W-1:0] pitch_sum;
  logic signed [CMD_W-1:0]   history [MAX_WINDOW_DEF];
  int                        wr_pos;
  int                        fill;

  function automatic longint clamp_wide(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic step_controller(input logic signed [PITCH_W-1:0] pitch_in,
                                 input logic signed [RATE_W-1:0] rate_in);
    longint p, r, integ, drive, spread, offset, lo_b, hi_b, lim, lower, upper;
    longint x, torque, cmd, sum, mag, avg;
    int wl;
    tick_result_t res;
    p = pitch_in;
    r = rate_in;
    integ = clamp_wide(longint'(pitch_sum) + p, INTEG_MIN, INTEG_MAX);
    pitch_sum = integ[INTEG_W-1:0];

    drive = longint'(k_pitch) * p + longint'(k_rate) * r;
    spread = longint'(slope) * ((p < 0) ? -p : p);
    offset = (longint'(k_integ) * integ) >>> 4;
    lo_b = offset - spread;
    hi_b = offset + spread;
    lim = longint'(limit) <<< 12;
    lower = (lo_b > -lim) ? lo_b : -lim;
    upper = (hi_b < lim) ? hi_b : lim;
    res.infeasible = lower > upper;
    if (res.infeasible) begin
      x = clamp_wide(drive, -lim, lim);
    end else begin
      x = clamp_wide(drive, lower, upper);
    end
    torque = (x + 2048) >>> 12;
    cmd = clamp_wide((torque * longint'(scale) + 2048) >>> 12, CMD_MIN, CMD_MAX);

    wl = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(win_len));
    if (wr_pos >= MAX_WINDOW_DEF) wr_pos = 0;
    history[wr_pos] = cmd[CMD_W-1:0];
    wr_pos = (wr_pos + 1 >= wl) ? 0 : wr_pos + 1;
    fill = (fill >= wl) ? wl : fill + 1;

    sum = 0;
    for (int i = 0; i < fill; i++) sum += history[i];
    mag = (sum < 0) ? -sum : sum;
    avg = (mag + fill / 2) / fill;
    if (sum < 0) avg = -avg;
    avg = clamp_wide(avg, CMD_MIN, CMD_MAX);

    res.wheel = avg[CMD_W-1:0];
    res.torque = torque[TORQUE_W-1:0];
    ticks_due.push_back(res);
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      k_pitch = PITCH_GAIN_RST;
      k_rate = RATE_GAIN_RST;
      slope = BOUND_SLOPE_RST;
      k_integ = INTEGRAL_GAIN_RST;
      limit = COMMAND_LIMIT_RST;
      scale = OUTPUT_SCALE_RST;
      win_len = WINDOW_LEN_RST;
      pitch_sum = '0;
      wr_pos = 0;
      fill = 0;
      fail_count = 0;
      ticks_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (ticks_due.size() == 0) begin
          report_mismatch("unexpected transfer, wheel_command", out_wheel_command, 0);
        end else begin
          want = ticks_due.pop_front();
          if (out_wheel_command !== want.wheel)
            report_mismatch("wheel_command", out_wheel_command, want.wheel);
          if (out_optimal_torque !== want.torque)
            report_mismatch("optimal_torque", out_optimal_torque, want.torque);
          if (out_infeasible !== want.infeasible)
            report_mismatch("infeasible", out_infeasible, want.infeasible);
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PITCH_GAIN: begin
            k_pitch = cfg_wdata;
          end
          CFG_RATE_GAIN: begin
            k_rate = cfg_wdata;
          end
          CFG_BOUND_SLOPE: begin
            slope = cfg_wdata;
          end
          CFG_INTEGRAL_GAIN: begin
            k_integ = cfg_wdata;
          end
          CFG_COMMAND_LIMIT: begin
            limit = cfg_wdata;
          end
          CFG_OUTPUT_SCALE: begin
            scale = cfg_wdata;
          end
          CFG_WINDOW_LEN: begin
            win_len = cfg_wdata[WLEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) step_controller(in_pitch_angle, in_pitch_rate);
    end
    outstanding <= ticks_due.size();
  end

endmodule

FILE: tb/balance_torque_controller_core_tb.sv
`timescale 1ns / 100ps
module balance_torque_controller_core_tb;
  import btc_pkg::*;

  localparam logic [2:0] CFG_SPARE = 3'd7;
  localparam int RANDOM_TICKS = 600;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic signed [PITCH_W-1:0] in_pitch_angle = '0;
  logic signed [RATE_W-1:0] in_pitch_rate = '0;
  logic [2:0] cfg_addr = '0;
  logic [GAIN_W-1:0] cfg_wdata = '0;

  logic in_stall;
  logic out_valid;
  logic signed [CMD_W-1:0] out_wheel_command;
  logic signed [TORQUE_W-1:0] out_optimal_torque;
  logic out_infeasible;

  int outstanding;
  int fail_count;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  always #2 clk = ~clk;

  balance_torque_controller_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pitch_angle     (in_pitch_angle),
    .in_pitch_rate      (in_pitch_rate),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_wheel_command  (out_wheel_command),
    .out_optimal_torque (out_optimal_torque),
    .out_infeasible     (out_infeasible),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata)
  );

  balance_torque_controller_core_chk chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pitch_angle     (in_pitch_angle),
    .in_pitch_rate      (in_pitch_rate),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_wheel_command  (out_wheel_command),
    .out_optimal_torque (out_optimal_torque),
    .out_infeasible     (out_infeasible),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .outstanding        (outstanding),
    .fail_count         (fail_count)
  );

  initial begin : watchdog
    #2_000_000;
    $display("balance_torque_controller_core_tb: errors");
    $finish;
  end

  // result side: random stalls (none while calm), or a long hold-off when asked
  initial begin : receiver
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        held = HOLD_CYCLES;
      end
      if (held > 0) begin
        out_stall <= 1'b1;
        held--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 36);
      end
    end
  end

  task automatic send_tick(input int pitch, input int rate);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pitch_angle <= PITCH_W'(pitch);
    in_pitch_rate <= RATE_W'(rate);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_tick();
    int pitch, rate;
    case ($urandom_range(9))
      0, 1: begin
        pitch = int'($signed(PITCH_W'($urandom)));
      end
      2: begin
        pitch = $urandom_range(1) ? 8191 : -8192;
      end
      default: begin
        pitch = int'($urandom_range(12868)) - 6434;
      end
    endcase
    if ($urandom_range(4) == 0) begin
      rate = int'($signed(RATE_W'($urandom)));
    end else begin
      rate = int'($urandom_range(81920)) - 40960;
    end
    send_tick(pitch, rate);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [GAIN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [GAIN_W-1:0] pg, rg, bs, ig, cl, os,
                               input logic [WLEN_W-1:0] wl);
    put_reg(CFG_PITCH_GAIN, pg);
    put_reg(CFG_RATE_GAIN, rg);
    put_reg(CFG_BOUND_SLOPE, bs);
    put_reg(CFG_INTEGRAL_GAIN, ig);
    put_reg(CFG_COMMAND_LIMIT, cl);
    put_reg(CFG_OUTPUT_SCALE, os);
    put_reg(CFG_WINDOW_LEN, {11'($urandom), wl});
    put_reg(CFG_SPARE, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain(input int nominal);
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range((nominal * 2 > 65535) ? 65535 : nominal * 2));
    endcase
  endfunction

  function automatic logic [WLEN_W-1:0] pick_window();
    case ($urandom_range(7))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'($urandom_range(31, 17));
      default: return 5'($urandom_range(16, 1));
    endcase
  endfunction

  initial begin : stimulus
    int done, count, phase;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, window not yet wrapped
    send_tick(0, 0);
    send_tick(6434, 0);
    send_tick(-6434, 0);
    send_tick(8191, 524287);
    send_tick(-8192, -524288);
    send_tick(100, -100);
    wait_idle();

    // full window so every history slot gets written
    load_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd16);
    send_tick(8191, 524287);
    send_tick(-8192, -524288);
    send_tick(8191, -524288);
    send_tick(-8192, 524287);
    send_tick(0, 0);
    send_tick(1, 1);
    send_tick(-1, -1);
    send_tick(4096, 0);
    send_tick(-4096, 0);
    send_tick(0, 4096);
    send_tick(0, -4096);
    send_tick(6434, 0);
    send_tick(-6434, 0);
    wait_idle();

    // zero limit box and zero slope: empty interval; window 0 acts as 1
    load_settings(PITCH_GAIN_RST, RATE_GAIN_RST, 16'h0000, 16'hFFFF, 16'h0000,
                  OUTPUT_SCALE_RST, 5'd0);
    send_tick(4096, 0);
    send_tick(-8192, 1000);
    send_tick(8191, -1000);
    wait_idle();

    // oversized window acts as the maximum
    load_settings(PITCH_GAIN_RST, RATE_GAIN_RST, 16'hFFFF, INTEGRAL_GAIN_RST, 16'd1,
                  16'h0000, 5'd31);
    send_tick(2000, -3000);
    send_tick(-2000, 3000);
    send_tick(0, 524287);
    wait_idle();

    done = 0;
    phase = 0;
    while (done < RANDOM_TICKS) begin
      if ($urandom_range(2) == 0) begin
        load_settings(PITCH_GAIN_RST, RATE_GAIN_RST, BOUND_SLOPE_RST, INTEGRAL_GAIN_RST,
                      COMMAND_LIMIT_RST, OUTPUT_SCALE_RST, pick_window());
      end else begin
        load_settings(pick_gain(PITCH_GAIN_RST), pick_gain(RATE_GAIN_RST),
                      pick_gain(BOUND_SLOPE_RST), pick_gain(INTEGRAL_GAIN_RST),
                      pick_gain(COMMAND_LIMIT_RST), pick_gain(OUTPUT_SCALE_RST),
                      pick_window());
      end
      calm = (phase == 2);
      if (phase == 4) hold_request = 1'b1;
      count = $urandom_range(80, 20);
      repeat (count) send_random_tick();
      done += count;
      phase++;
      wait_idle();
    end
    calm = 1'b0;

    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("balance_torque_controller_core_tb: clean");
    end else begin
      $display("balance_torque_controller_core_tb: errors");
    end
    $finish;
  end

endmodule
